[hdl/point_cloud_angular_bin_range_scan_macros.svh]
// assertion macros for the angular bin range scan
`ifndef POINT_CLOUD_ANGULAR_BIN_RANGE_SCAN_MACROS_SVH
`define POINT_CLOUD_ANGULAR_BIN_RANGE_SCAN_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PCAB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PCAB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PCAB_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PCAB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[hdl/pcab_pkg.sv]
package pcab_pkg;
    localparam int CORDIC_STEPS = 18;
    localparam int ANG_ONE = 65536;
    localparam int ANG_BITS = 28;

    typedef enum logic {
        OP_ACCUM   = 1'b0,
        OP_READOUT = 1'b1
    } op_t;

    function automatic logic signed [ANG_BITS-1:0] atan_q16(input logic [4:0] i);
        case (i)
            5'd0:  atan_q16 = 28'sd2949120;
            5'd1:  atan_q16 = 28'sd1740967;
            5'd2:  atan_q16 = 28'sd919879;
            5'd3:  atan_q16 = 28'sd466945;
            5'd4:  atan_q16 = 28'sd234379;
            5'd5:  atan_q16 = 28'sd117304;
            5'd6:  atan_q16 = 28'sd58666;
            5'd7:  atan_q16 = 28'sd29335;
            5'd8:  atan_q16 = 28'sd14668;
            5'd9:  atan_q16 = 28'sd7334;
            5'd10: atan_q16 = 28'sd3667;
            5'd11: atan_q16 = 28'sd1833;
            5'd12: atan_q16 = 28'sd917;
            5'd13: atan_q16 = 28'sd458;
            5'd14: atan_q16 = 28'sd229;
            5'd15: atan_q16 = 28'sd115;
            5'd16: atan_q16 = 28'sd57;
            5'd17: atan_q16 = 28'sd29;
            default: atan_q16 = '0;
        endcase
    endfunction
endpackage

[hdl/pcab_if.sv]
interface pcab_in_if #(parameter int COORD_BITS = 16);
    logic                         valid;
    logic                         ready;
    logic                         operation;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_z;
    logic [8:0]                   read_bin;
    modport source (output valid, operation, point_x, point_y, point_z, read_bin,
                    input ready);
    modport sink (input valid, operation, point_x, point_y, point_z, read_bin,
                  output ready);
endinterface

interface pcab_out_if #(parameter int COUNT_BITS = 16);
    logic                  valid;
    logic                  ready;
    logic [8:0]            bin_number;
    logic [15:0]           range_mm;
    logic                  empty_res;
    logic [COUNT_BITS-1:0] points_in_bin;
    modport source (output valid, bin_number, range_mm, empty_res, points_in_bin,
                    input ready);
    modport sink (input valid, bin_number, range_mm, empty_res, points_in_bin,
                  output ready);
endinterface

[hdl/pcab_ram.sv]
module pcab_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 361
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[hdl/pcab_cordic.sv]
// iterative vectoring cordic, one step per cycle, returns clamped bin
module pcab_cordic #(
    parameter int COORD_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [COORD_BITS-1:0] x,
    input  logic signed [COORD_BITS-1:0] y,
    output logic                         done,
    output logic signed [10:0]           bin
);
    import pcab_pkg::*;
    localparam int VB = COORD_BITS + 20;

    logic signed [VB-1:0]       cx_reg, cy_reg;
    logic signed [ANG_BITS-1:0] z_reg, lo_reg, hi_reg;
    logic [4:0]                 step_reg;
    logic                       busy_reg, done_reg;
    logic signed [VB-1:0]       dx, dy;
    logic signed [COORD_BITS:0] ex, ey;
    logic signed [ANG_BITS-1:0] lo_n, hi_n, zc, zb;

    assign ex = {x[COORD_BITS-1], x};
    assign ey = {y[COORD_BITS-1], y};
    assign dx = cy_reg >>> step_reg;
    assign dy = cx_reg >>> step_reg;

    // octant bounds in whole degrees, shifted to q16 at the clamp
    always_comb
    begin
        if (ey < 0)
        begin
            if (ex + ey < 0) begin lo_n = -28'sd90; hi_n = -28'sd45; end
            else begin lo_n = -28'sd45; hi_n = 28'sd0; end
        end
        else if (ex > 0)
        begin
            if (ex > ey) begin lo_n = 28'sd0; hi_n = 28'sd45; end
            else begin lo_n = 28'sd45; hi_n = 28'sd90; end
        end
        else
        begin
            if (ex + ey > 0) begin lo_n = 28'sd90; hi_n = 28'sd135; end
            else begin lo_n = 28'sd135; hi_n = 28'sd180; end
        end
    end

    // clamp and bin
    always_comb
    begin
        zc = z_reg;
        if (zc < (lo_reg <<< 16)) zc = lo_reg <<< 16;
        if (zc > (hi_reg <<< 16) - 28'sd1) zc = (hi_reg <<< 16) - 28'sd1;
        zb = zc + 28'sd5898240;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            cx_reg   <= '0;
            cy_reg   <= '0;
            z_reg    <= '0;
            lo_reg   <= '0;
            hi_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                lo_reg   <= lo_n;
                hi_reg   <= hi_n;
                if (ex <= 0)
                begin
                    cx_reg <= VB'(ey) <<< 16;
                    cy_reg <= -(VB'(ex) <<< 16);
                    z_reg  <= 28'sd5898240;
                end
                else
                begin
                    cx_reg <= VB'(ex) <<< 16;
                    cy_reg <= VB'(ey) <<< 16;
                    z_reg  <= '0;
                end
            end
            else if (busy_reg)
            begin
                if (cy_reg >= 0)
                begin
                    cx_reg <= cx_reg + dx;
                    cy_reg <= cy_reg - dy;
                    z_reg  <= z_reg + atan_q16(step_reg);
                end
                else
                begin
                    cx_reg <= cx_reg - dx;
                    cy_reg <= cy_reg + dy;
                    z_reg  <= z_reg - atan_q16(step_reg);
                end
                step_reg <= step_reg + 5'd1;
                if (step_reg == 5'(CORDIC_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign bin  = 11'(zb >>> 16);
endmodule

[hdl/pcab_range.sv]
// mean by restoring division, squares, then bit-pair square root
module pcab_range #(
    parameter int COUNT_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic signed [31:0]    sx,
    input  logic signed [31:0]    sy,
    input  logic [COUNT_BITS-1:0] n,
    output logic                  done,
    output logic [15:0]           range_mm
);
    typedef enum logic [2:0] {S_IDLE, S_DIV, S_SQX, S_SQY, S_ROOT, S_DONE} st_t;
    st_t         st_reg;
    logic [31:0] qx_reg, qy_reg, rx_reg, ry_reg, ax_reg, ay_reg;
    logic [COUNT_BITS-1:0] n_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] v_reg, res_reg, bit_reg;
    logic [32:0] rxs, rys;
    logic [63:0] sum;
    logic [31:0] sq_op;
    logic [63:0] sq;

    assign rxs = {rx_reg, ax_reg[31]};
    assign rys = {ry_reg, ay_reg[31]};
    assign sum = res_reg + bit_reg;

    // one shared multiplier; the quotient magnitude squares to the mean squared
    assign sq_op = (st_reg == S_SQX) ? qx_reg : qy_reg;
    assign sq    = sq_op * sq_op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= S_IDLE;
            qx_reg  <= '0;
            qy_reg  <= '0;
            rx_reg  <= '0;
            ry_reg  <= '0;
            ax_reg  <= '0;
            ay_reg  <= '0;
            n_reg   <= '0;
            cnt_reg <= '0;
            v_reg   <= '0;
            res_reg <= '0;
            bit_reg <= '0;
        end
        else
        begin
            case (st_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        ax_reg  <= sx[31] ? 32'(-sx) : sx;
                        ay_reg  <= sy[31] ? 32'(-sy) : sy;
                        n_reg   <= n;
                        rx_reg  <= '0;
                        ry_reg  <= '0;
                        cnt_reg <= '0;
                        st_reg  <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    ax_reg <= ax_reg << 1;
                    ay_reg <= ay_reg << 1;
                    if (rxs >= 33'(n_reg))
                    begin
                        rx_reg <= 32'(rxs - 33'(n_reg));
                        qx_reg <= {qx_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        rx_reg <= 32'(rxs);
                        qx_reg <= {qx_reg[30:0], 1'b0};
                    end
                    if (rys >= 33'(n_reg))
                    begin
                        ry_reg <= 32'(rys - 33'(n_reg));
                        qy_reg <= {qy_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        ry_reg <= 32'(rys);
                        qy_reg <= {qy_reg[30:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd31) st_reg <= S_SQX;
                end
                S_SQX:
                begin
                    v_reg  <= sq;
                    st_reg <= S_SQY;
                end
                S_SQY:
                begin
                    v_reg   <= v_reg + sq;
                    res_reg <= '0;
                    bit_reg <= 64'd1 << 62;
                    st_reg  <= S_ROOT;
                end
                S_ROOT:
                begin
                    if (v_reg >= sum)
                    begin
                        v_reg   <= v_reg - sum;
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    if (bit_reg[0]) st_reg <= S_DONE;
                end
                S_DONE: st_reg <= S_IDLE;
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    assign done     = st_reg == S_DONE;
    assign range_mm = res_reg > 64'd65535 ? 16'hFFFF : res_reg[15:0];
endmodule

[hdl/point_cloud_angular_bin_range_scan.sv]
// angular bin range scan
// in channel: one transfer per item; operation accumulate adds a point, readout
// reports and clears one bin. out channel: one transfer per readout.
// accumulate: filter, 18-step iterative cordic, then read-modify-write of the
// bin memory.
// readout: memory read, restoring divide for both means, two squares and a
// 32-step square root; the result register is loaded when the root is done.
// filtered points are dropped in idle; out-of-range bins after the cordic.
// an empty bin answers after the memory read, a bin beyond NUM_BINS from idle.
// one item is worked at a time; in.ready is high only while idle with no
// result waiting.
// reset clears z_band_mm to 10, then a clearing pass writes zero to every bin,
// one bin per cycle, before the first item is taken.
// config writes are taken at any time through cfg_we/cfg_wdata.
// a stalled receiver holds the result register; the next item is not taken
// until the result transfers.
module point_cloud_angular_bin_range_scan #(
    parameter int NUM_BINS   = 361,
    parameter int COORD_BITS = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [9:0] cfg_wdata,
    pcab_in_if.sink    in_ch,
    pcab_out_if.source out_ch
);
    import pcab_pkg::*;
    `include "point_cloud_angular_bin_range_scan_macros.svh"

    localparam int AW = $clog2(NUM_BINS);
    localparam int MW = 64 + COUNT_BITS;
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_CORDIC, S_READ, S_WRITE, S_RANGE
    } st_t;

    st_t                  st_reg;
    logic [9:0]           zband_reg;
    logic [AW-1:0]        addr_reg;
    logic                 op_reg;
    logic [8:0]           rbin_reg;
    logic signed [COORD_BITS-1:0] px_reg, py_reg;
    logic                 we;
    logic [MW-1:0]        wdata, rdata;
    logic                 cstart, cdone, rstart, rdone;
    logic signed [10:0]   cbin;
    logic [15:0]          rng;
    logic signed [COORD_BITS:0] az;
    logic signed [31:0]   sx, sy;
    logic [COUNT_BITS-1:0] cnt;
    logic signed [32:0]   nsx, nsy;
    logic [8:0]           ob_reg;
    logic [15:0]          orng_reg;
    logic                 oemp_reg;
    logic [COUNT_BITS-1:0] ocnt_reg;
    logic                 ov_reg;

    assign sx  = $signed(rdata[MW-1 -: 32]);
    assign sy  = $signed(rdata[MW-33 -: 32]);
    assign cnt = rdata[COUNT_BITS-1:0];
    assign nsx = 33'(sx) + 33'(px_reg);
    assign nsy = 33'(sy) + 33'(py_reg);
    assign az  = in_ch.point_z[COORD_BITS-1] ? -(COORD_BITS+1)'(in_ch.point_z)
                                             : (COORD_BITS+1)'(in_ch.point_z);

    // bin memory: sum x, sum y, count
    pcab_ram #(.WIDTH(MW), .DEPTH(NUM_BINS)) u_ram (
        .clk(clk), .we(we), .waddr(addr_reg), .wdata(wdata),
        .raddr(addr_reg), .rdata(rdata)
    );

    // cordic takes the point straight from the bus at the accepting edge
    pcab_cordic #(.COORD_BITS(COORD_BITS)) u_cordic (
        .clk(clk), .rst_n(rst_n), .start(cstart), .x(in_ch.point_x), .y(in_ch.point_y),
        .done(cdone), .bin(cbin)
    );

    pcab_range #(.COUNT_BITS(COUNT_BITS)) u_range (
        .clk(clk), .rst_n(rst_n), .start(rstart), .sx(sx), .sy(sy), .n(cnt),
        .done(rdone), .range_mm(rng)
    );

    // write data: zero for clear and readout, saturating sums for accumulate
    always_comb
    begin
        we = 1'b0;
        wdata = '0;
        case (st_reg)
            S_CLEAR: we = 1'b1;
            S_WRITE:
            begin
                if (op_reg == OP_READOUT)
                begin
                    we = cnt != '0;
                end
                else if (cnt != CMAX)
                begin
                    we = 1'b1;
                    wdata[MW-1 -: 32] = nsx > 33'sd2147483647 ? 32'h7FFFFFFF :
                        nsx < -33'sd2147483648 ? 32'h80000000 : nsx[31:0];
                    wdata[MW-33 -: 32] = nsy > 33'sd2147483647 ? 32'h7FFFFFFF :
                        nsy < -33'sd2147483648 ? 32'h80000000 : nsy[31:0];
                    wdata[COUNT_BITS-1:0] = cnt + 1'b1;
                end
            end
            default: we = 1'b0;
        endcase
    end

    assign rstart = st_reg == S_WRITE && op_reg == OP_READOUT && cnt != '0;
    assign cstart = st_reg == S_IDLE && in_ch.valid && !ov_reg
                    && in_ch.operation == OP_ACCUM && az < (COORD_BITS+1)'(zband_reg)
                    && (in_ch.point_x > 0 || in_ch.point_y > 0);
    assign in_ch.ready = st_reg == S_IDLE && !ov_reg;

    // control sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= S_CLEAR;
            addr_reg  <= '0;
            zband_reg <= 10'd10;
            ov_reg    <= 1'b0;
            op_reg    <= 1'b0;
            px_reg    <= '0;
            py_reg    <= '0;
            rbin_reg  <= '0;
            ob_reg    <= '0;
            orng_reg  <= '0;
            oemp_reg  <= 1'b0;
            ocnt_reg  <= '0;
        end
        else
        begin
            if (cfg_we) zband_reg <= cfg_wdata;
            if (ov_reg && out_ch.ready) ov_reg <= 1'b0;
            case (st_reg)
                S_CLEAR:
                begin
                    addr_reg <= addr_reg + 1'b1;
                    if (addr_reg == AW'(NUM_BINS - 1))
                    begin
                        st_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_ch.valid && !ov_reg)
                    begin
                        op_reg   <= in_ch.operation;
                        px_reg   <= in_ch.point_x;
                        py_reg   <= in_ch.point_y;
                        rbin_reg <= in_ch.read_bin;
                        if (in_ch.operation == OP_READOUT)
                        begin
                            if (32'(in_ch.read_bin) < NUM_BINS)
                            begin
                                addr_reg <= AW'(in_ch.read_bin);
                                st_reg   <= S_READ;
                            end
                            else
                            begin
                                ob_reg   <= in_ch.read_bin;
                                orng_reg <= '0;
                                oemp_reg <= 1'b1;
                                ocnt_reg <= '0;
                                ov_reg   <= 1'b1;
                            end
                        end
                        else if (cstart)
                        begin
                            st_reg <= S_CORDIC;
                        end
                    end
                end
                S_CORDIC:
                begin
                    if (cdone)
                    begin
                        if (cbin >= 0 && 32'(cbin) < NUM_BINS)
                        begin
                            addr_reg <= AW'(cbin);
                            st_reg   <= S_READ;
                        end
                        else
                        begin
                            st_reg <= S_IDLE;
                        end
                    end
                end
                S_READ: st_reg <= S_WRITE;
                S_WRITE:
                begin
                    if (op_reg == OP_READOUT)
                    begin
                        ob_reg   <= rbin_reg;
                        ocnt_reg <= cnt;
                        if (cnt == '0)
                        begin
                            orng_reg <= '0;
                            oemp_reg <= 1'b1;
                            ov_reg   <= 1'b1;
                            st_reg   <= S_IDLE;
                        end
                        else
                        begin
                            st_reg <= S_RANGE;
                        end
                    end
                    else
                    begin
                        st_reg <= S_IDLE;
                    end
                end
                S_RANGE:
                begin
                    if (rdone)
                    begin
                        orng_reg <= rng;
                        oemp_reg <= 1'b0;
                        ov_reg   <= 1'b1;
                        st_reg   <= S_IDLE;
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    assign out_ch.valid         = ov_reg;
    assign out_ch.bin_number    = ob_reg;
    assign out_ch.range_mm      = orng_reg;
    assign out_ch.empty_res     = oemp_reg;
    assign out_ch.points_in_bin = ocnt_reg;

    `PCAB_ASSERT_IMP(a_ready_idle, clk, rst_n, in_ch.ready, st_reg == S_IDLE)
    `PCAB_ASSERT_IMP(a_empty_zero, clk, rst_n, ov_reg && oemp_reg, orng_reg == '0 && ocnt_reg == '0)
    `PCAB_ASSERT_NEXT(a_hold, clk, rst_n, ov_reg && !out_ch.ready, ov_reg && $stable(ob_reg))
    `PCAB_ASSERT_IMP(a_nonempty_cnt, clk, rst_n, ov_reg && !oemp_reg, ocnt_reg != '0)
endmodule
